[hdl/dasch_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dasch_pkg: shared types and constants of the disk arm scheduler
// Widths, policy and register codes, controller states, command and status.
// ---------------------------------------------------------------------------
package dasch_pkg;

	localparam int MAX_REQ = 32;
	localparam int CYL_W   = 16;
	localparam int ADDR_W  = $clog2(MAX_REQ);
	localparam int CNT_W   = $clog2(MAX_REQ + 1);
	localparam int SEEK_W  = 22;
	localparam int TOT_W   = 21;
	localparam int CHG_W   = 6;
	localparam int PRI_W   = CYL_W + 1;
	localparam int OUT_W   = 64;
	localparam int IDX_W   = 2;

	// policy codes
	localparam logic [1:0] POL_FCFS  = 2'd0;
	localparam logic [1:0] POL_SSTF  = 2'd1;
	localparam logic [1:0] POL_SCAN  = 2'd2;
	localparam logic [1:0] POL_CSCAN = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_START_CYL = 2'd0;
	localparam logic [IDX_W-1:0] REG_START_DIR = 2'd1;
	localparam logic [IDX_W-1:0] REG_POLICY    = 2'd2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              load;
		logic [ADDR_W-1:0] load_addr;
		logic              run_start;
		logic              scan_clear;
		logic              rd_valid;
		logic [ADDR_W-1:0] rd_addr;
		logic              emit;
		logic              last_emit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

[hdl/dasch_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dasch_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dasch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/dasch_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dasch_ctrl: scheduler controller
// Load sequencing, one selection pass over the store per served request.
// ---------------------------------------------------------------------------
module dasch_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	input  dasch_pkg::stat_t stat,
	output dasch_pkg::cmd_t  cmd
);

	dasch_pkg::state_t state_q, state_d;
	logic [dasch_pkg::CNT_W-1:0]  cnt_q;
	logic [dasch_pkg::CNT_W-1:0]  emit_cnt_q;
	logic [dasch_pkg::ADDR_W-1:0] scan_q;
	logic [dasch_pkg::CNT_W-1:0]  cnt_m1;
	logic                         accept;
	logic                         scan_end;
	logic                         run_end;
	logic                         room;

	assign cnt_m1   = dasch_pkg::CNT_W'(cnt_q - dasch_pkg::CNT_W'(1));
	assign accept   = in_valid && (state_q == dasch_pkg::ST_LOAD);
	assign room     = cnt_q < dasch_pkg::CNT_W'(dasch_pkg::MAX_REQ);
	assign scan_end = scan_q == cnt_m1[dasch_pkg::ADDR_W-1:0];
	assign run_end  = emit_cnt_q == cnt_m1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dasch_pkg::ST_LOAD: begin
				if (accept && in_last) state_d = dasch_pkg::ST_SCAN;
			end
			dasch_pkg::ST_SCAN: begin
				if (scan_end) state_d = dasch_pkg::ST_DRAIN;
			end
			dasch_pkg::ST_DRAIN: state_d = dasch_pkg::ST_EMIT;
			dasch_pkg::ST_EMIT: begin
				if (!stat.out_busy) begin
					state_d = run_end ? dasch_pkg::ST_LOAD : dasch_pkg::ST_SCAN;
				end
			end
			default: state_d = dasch_pkg::ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = state_q == dasch_pkg::ST_LOAD;
		cmd            = '0;
		cmd.load       = accept && room;
		cmd.load_addr  = cnt_q[dasch_pkg::ADDR_W-1:0];
		cmd.rd_addr    = scan_q;
		case (state_q)
			dasch_pkg::ST_LOAD: begin
				cmd.run_start  = accept && in_last;
				cmd.scan_clear = accept && in_last;
			end
			dasch_pkg::ST_SCAN: cmd.rd_valid = 1'b1;
			dasch_pkg::ST_EMIT: begin
				cmd.emit       = !stat.out_busy;
				cmd.last_emit  = !stat.out_busy && run_end;
				cmd.scan_clear = !stat.out_busy && !run_end;
			end
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dasch_pkg::ST_LOAD;
			cnt_q      <= '0;
			emit_cnt_q <= '0;
			scan_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) cnt_q <= dasch_pkg::CNT_W'(cnt_q + dasch_pkg::CNT_W'(1));
			if (cmd.run_start) emit_cnt_q <= '0;
			if (cmd.scan_clear) scan_q <= '0;
			else if (state_q == dasch_pkg::ST_SCAN && !scan_end) begin
				scan_q <= dasch_pkg::ADDR_W'(scan_q + dasch_pkg::ADDR_W'(1));
			end
			if (cmd.emit) begin
				if (cmd.last_emit) cnt_q <= '0;
				else emit_cnt_q <= dasch_pkg::CNT_W'(emit_cnt_q + dasch_pkg::CNT_W'(1));
			end
		end
	end

endmodule

[hdl/dasch_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dasch_dp: scheduler datapath
// Request store, served marks, priority compare, head and seek tracking.
// ---------------------------------------------------------------------------
module dasch_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dasch_pkg::cmd_t               cmd,
	output dasch_pkg::stat_t              stat,
	input  logic [dasch_pkg::CYL_W-1:0]   start_cyl,
	input  logic                          start_dir,
	input  logic [1:0]                    policy,
	input  logic [dasch_pkg::CYL_W-1:0]   req_cyl,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [dasch_pkg::OUT_W-1:0]   out_data,
	output logic                          out_last
);

	logic [dasch_pkg::CYL_W-1:0]   rdata;
	logic                          rd_valid_s1;
	logic [dasch_pkg::ADDR_W-1:0]  rd_idx_s1;
	logic [dasch_pkg::MAX_REQ-1:0] marks_q;
	logic [dasch_pkg::CYL_W-1:0]   head_q, st_q;
	logic                          dir_q, phase2_q;
	logic [1:0]                    mode_q;
	logic [dasch_pkg::SEEK_W-1:0]  seek_q, seek_d;
	logic [dasch_pkg::CHG_W-1:0]   chg_q, chg_d;
	logic                          found_q;
	logic [dasch_pkg::PRI_W-1:0]   best_pri_q, pri;
	logic [dasch_pkg::ADDR_W-1:0]  best_idx_q;
	logic [dasch_pkg::CYL_W-1:0]   best_cyl_q;
	logic [dasch_pkg::CYL_W-1:0]   cand_dist, mdist, key1, key2;
	logic                          set1, take, rev, tgt_ge;

	dasch_ram #(.WIDTH(dasch_pkg::CYL_W), .DEPTH(dasch_pkg::MAX_REQ)) u_store (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (cmd.load_addr),
		.wdata (req_cyl),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	// candidate priority, lower wins, first found wins a tie
	always_comb begin
		cand_dist = (rdata >= head_q) ? rdata - head_q : head_q - rdata;
		set1      = dir_q ? (rdata >= st_q) : (rdata < st_q);
		key1      = dir_q ? rdata : ~rdata;
		key2      = ((mode_q == dasch_pkg::POL_CSCAN) == dir_q) ? rdata : ~rdata;
		case (mode_q)
			dasch_pkg::POL_FCFS: pri = '0;
			dasch_pkg::POL_SSTF: pri = {1'b0, cand_dist};
			default:             pri = set1 ? {1'b0, key1} : {1'b1, key2};
		endcase
		take = rd_valid_s1 && !marks_q[rd_idx_s1] && (!found_q || pri < best_pri_q);
	end

	// move of the selected request
	always_comb begin
		tgt_ge = best_cyl_q >= head_q;
		mdist  = tgt_ge ? best_cyl_q - head_q : head_q - best_cyl_q;
		if (mode_q == dasch_pkg::POL_FCFS || mode_q == dasch_pkg::POL_SSTF) begin
			rev = (tgt_ge && !dir_q) || (!tgt_ge && dir_q);
		end else begin
			rev = best_pri_q[dasch_pkg::PRI_W-1] && !phase2_q;
		end
		seek_d = dasch_pkg::SEEK_W'(seek_q + dasch_pkg::SEEK_W'(mdist));
		chg_d  = dasch_pkg::CHG_W'(chg_q + dasch_pkg::CHG_W'(rev));
	end

	assign stat.out_busy = out_valid && !out_ready;

	// read pipeline and best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_valid;
			if (cmd.scan_clear) found_q <= 1'b0;
			else if (take) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cmd.rd_addr;
		if (take) begin
			best_pri_q <= pri;
			best_idx_q <= rd_idx_s1;
			best_cyl_q <= rdata;
		end
	end

	// served marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
		end else if (cmd.last_emit) begin
			marks_q <= '0;
		end else begin
			if (cmd.load) marks_q[cmd.load_addr] <= 1'b0;
			if (cmd.emit) marks_q[best_idx_q] <= 1'b1;
		end
	end

	// head, direction and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			st_q     <= '0;
			dir_q    <= 1'b0;
			mode_q   <= dasch_pkg::POL_FCFS;
			phase2_q <= 1'b0;
			seek_q   <= '0;
			chg_q    <= '0;
		end else if (cmd.run_start) begin
			head_q   <= start_cyl;
			st_q     <= start_cyl;
			dir_q    <= start_dir;
			mode_q   <= policy;
			phase2_q <= 1'b0;
			seek_q   <= '0;
			chg_q    <= '0;
		end else if (cmd.emit) begin
			head_q <= best_cyl_q;
			seek_q <= seek_d;
			chg_q  <= chg_d;
			if (best_pri_q[dasch_pkg::PRI_W-1]) phase2_q <= 1'b1;
			if ((mode_q == dasch_pkg::POL_FCFS || mode_q == dasch_pkg::POL_SSTF) && rev) begin
				dir_q <= !dir_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data <= {4'd0, chg_d, seek_d[dasch_pkg::TOT_W-1:0], rev, mdist, best_cyl_q};
			out_last <= cmd.last_emit;
		end
	end

endmodule

[hdl/disk_arm_scheduler.sv]
`timescale 1ns / 1ps
// Throughput: one load per cycle while loading. After the last load every served
// request needs one selection pass over the N stored requests (one RAM read a cycle),
// then a drain and an emit state that waits on a stalled output; one beat per pass.
// Reset: arst_n clears the controller, counts, served marks, head and totals at once;
// start_dir resets to 1.
// ---------------------------------------------------------------------------
// disk_arm_scheduler: FCFS, SSTF, SCAN and C-SCAN disk arm scheduler
// Loads cylinder requests, then streams out the service order.
// ---------------------------------------------------------------------------
module disk_arm_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dasch_pkg::IDX_W-1:0] cfg_index,
	input  logic [15:0]                 cfg_wdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // request_cylinder
	input  logic                        s_axis_tlast,  // last_request
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// served_cylinder, move_distance, reversed, total_seek, change_total, zero pad
	output logic [63:0]                 m_axis_tdata,
	output logic                        m_axis_tlast   // last_served
);

	logic [dasch_pkg::CYL_W-1:0] start_cyl_q;
	logic                        start_dir_q;
	logic [1:0]                  policy_q;
	dasch_pkg::cmd_t             cmd;
	dasch_pkg::stat_t            stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_cyl_q <= '0;
			start_dir_q <= 1'b1;
			policy_q    <= dasch_pkg::POL_FCFS;
		end else if (cfg_we) begin
			case (cfg_index)
				dasch_pkg::REG_START_CYL: start_cyl_q <= cfg_wdata;
				dasch_pkg::REG_START_DIR: start_dir_q <= cfg_wdata[0];
				dasch_pkg::REG_POLICY:    policy_q    <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	dasch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dasch_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.start_cyl (start_cyl_q),
		.start_dir (start_dir_q),
		.policy    (policy_q),
		.req_cyl   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

[hdl/dasch_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dasch_checker: port level checks of the disk arm scheduler
// Output hold, run exclusivity and running total sanity.
// ---------------------------------------------------------------------------
module dasch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// last load starts a run, loading stops
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("load taken right after last request");

	// no loading while a run is still mid-way
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("load accepted during a run");

	// running total covers this move
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[53:33] >= {5'd0, m_axis_tdata[31:16]})
		else $error("total seek below move distance");

endmodule

bind disk_arm_scheduler dasch_checker u_dasch_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
